[hw/rtl/atpr_pkg.sv]
`timescale 1ns / 1ps

package atpr_pkg;

	localparam int AXIS_W  = 16;
	localparam int PITCH_W = 15;
	localparam int ROLL_W  = 16;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;

	// Square root of (y*y + z*z) * 65536: 48-bit radicand, 24 root digits.
	localparam int SUMSQ_W   = 32;
	localparam int ROOT_W    = 24;
	localparam int REM_W     = ROOT_W + 2;
	localparam int SQ_DIGITS = ROOT_W;

	// Vector components carry 8 extra fraction bits plus room for CORDIC gain.
	localparam int VEC_W  = 27;
	localparam int VEC_SH = 8;

	// Angles in degrees * 2^20.
	localparam int ANG_W     = 30;
	localparam int ROUND_SH  = 13;
	localparam logic signed [ANG_W-1:0] ANG_180    = ANG_W'(180 * (1 << 20));
	localparam logic signed [ANG_W-1:0] ROUND_BIAS = ANG_W'(1 << (ROUND_SH - 1));
	localparam logic signed [ANG_W-1:0] PITCH_LIM  = ANG_W'(11520);
	localparam logic signed [ANG_W-1:0] ROLL_LIM   = ANG_W'(23040);

	typedef struct packed {
		logic [SUMSQ_W-1:0]       sumsq;
		logic [REM_W-1:0]         rem;
		logic [ROOT_W-1:0]        root;
		logic signed [AXIS_W:0]   nx;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
	} sq_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
		logic signed [ANG_W-1:0] ang;
		logic                    zero;
	} lane_t;

	typedef struct packed {
		lane_t pitch;
		lane_t roll;
	} cd_t;

	// atan(2^-i) in degrees * 2^20, rounded to nearest.
	function automatic logic signed [ANG_W-1:0] atan_lut(input int idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			0:       v = ANG_W'(47185920);
			1:       v = ANG_W'(27855475);
			2:       v = ANG_W'(14718068);
			3:       v = ANG_W'(7471121);
			4:       v = ANG_W'(3750058);
			5:       v = ANG_W'(1876857);
			6:       v = ANG_W'(938658);
			7:       v = ANG_W'(469357);
			8:       v = ANG_W'(234682);
			9:       v = ANG_W'(117342);
			10:      v = ANG_W'(58671);
			11:      v = ANG_W'(29335);
			12:      v = ANG_W'(14668);
			13:      v = ANG_W'(7334);
			14:      v = ANG_W'(3667);
			15:      v = ANG_W'(1833);
			16:      v = ANG_W'(917);
			17:      v = ANG_W'(458);
			18:      v = ANG_W'(229);
			19:      v = ANG_W'(115);
			20:      v = ANG_W'(57);
			21:      v = ANG_W'(29);
			22:      v = ANG_W'(14);
			23:      v = ANG_W'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/atpr_if.sv]
`timescale 1ns / 1ps

interface atpr_in_if;
	import atpr_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [AXIS_W-1:0] accel_x_raw;
	logic signed [AXIS_W-1:0] accel_y_raw;
	logic signed [AXIS_W-1:0] accel_z_raw;

	modport source(output valid, accel_x_raw, accel_y_raw, accel_z_raw, input ready);
	modport sink(input valid, accel_x_raw, accel_y_raw, accel_z_raw, output ready);
endinterface

interface atpr_out_if;
	import atpr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [PITCH_W-1:0] pitch_deg;
	logic signed [ROLL_W-1:0]  roll_deg;

	modport source(output valid, pitch_deg, roll_deg, input ready);
	modport sink(input valid, pitch_deg, roll_deg, output ready);
endinterface

[hw/rtl/atpr_sqrt_cell.sv]
`timescale 1ns / 1ps

module atpr_sqrt_cell #(
	parameter int DIGIT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  atpr_pkg::sq_t   up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output atpr_pkg::sq_t   dn_data
);
	import atpr_pkg::*;

	logic                      v_q;
	sq_t                       d_q;
	sq_t                       nxt;
	logic [SUMSQ_W+15:0]       rad;
	logic [REM_W+1:0]          cur;
	logic [REM_W+1:0]          trial;

	// One root bit per cell, restoring digit-by-digit method.
	always_comb begin
		rad   = {up_data.sumsq, 16'b0};
		cur   = {up_data.rem, rad[2*DIGIT+1 -: 2]};
		trial = {2'b00, up_data.root, 2'b01};
		nxt   = up_data;
		if (cur >= trial) begin
			nxt.rem  = REM_W'(cur - trial);
			nxt.root = {up_data.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(cur);
			nxt.root = {up_data.root[ROOT_W-2:0], 1'b0};
		end
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = d_q;

endmodule

[hw/rtl/atpr_cordic_cell.sv]
`timescale 1ns / 1ps

module atpr_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  atpr_pkg::cd_t   up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output atpr_pkg::cd_t   dn_data
);
	import atpr_pkg::*;

	localparam logic signed [ANG_W-1:0] STEP = atan_lut(IDX);

	logic v_q;
	cd_t  d_q;
	cd_t  nxt;

	function automatic lane_t rotate(input lane_t l);
		lane_t                   r;
		logic signed [VEC_W-1:0] da;
		logic signed [VEC_W-1:0] db;
		da = l.a >>> IDX;
		db = l.b >>> IDX;
		r  = l;
		if (!l.a[VEC_W-1]) begin
			r.b   = l.b + da;
			r.a   = l.a - db;
			r.ang = l.ang + STEP;
		end else begin
			r.b   = l.b - da;
			r.a   = l.a + db;
			r.ang = l.ang - STEP;
		end
		return r;
	endfunction

	always_comb begin
		nxt.pitch = rotate(up_data.pitch);
		nxt.roll  = rotate(up_data.roll);
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = d_q;

endmodule

[hw/rtl/accel_tilt_pitch_roll.sv]
`timescale 1ns / 1ps

// Channel | Dir | Fields                                   | Word
// sample  | in  | accel_x_raw, accel_y_raw, accel_z_raw    | one raw 3-axis sample
// tilt    | out | pitch_deg, roll_deg (degrees * 128)      | one result per sample
//
// The pipeline is the squares and sum stages, 24 square root cells, a quadrant cell,
// one cell per CORDIC micro-rotation and the output register.
// Each stage holds its own valid bit; a new word is taken every cycle unless a stall reaches the input.
// A stalled tilt word holds only the stages behind it; empty stages keep filling.
// Reset clears the valid bits only.
module accel_tilt_pitch_roll #(
	parameter int CORDIC_STAGES = atpr_pkg::CORDIC_STAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	atpr_in_if.sink    sample,
	atpr_out_if.source tilt
);
	import atpr_pkg::*;

	localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

	// Squares stage.
	logic                     v_s1;
	logic                     rdy_s1;
	logic signed [AXIS_W:0]   nx_s1;
	logic signed [AXIS_W-1:0] y_s1;
	logic signed [AXIS_W-1:0] z_s1;
	logic [2*AXIS_W-2:0]      ysq_s1;
	logic [2*AXIS_W-2:0]      zsq_s1;
	logic signed [2*AXIS_W-1:0] yprod;
	logic signed [2*AXIS_W-1:0] zprod;

	// Sum stage.
	logic v_s2;
	logic rdy_s2;
	sq_t  d_s2;

	sq_t  sq_d [0:SQ_DIGITS];
	logic sq_v [0:SQ_DIGITS];
	logic sq_r [0:SQ_DIGITS];

	// Quadrant stage feeds the CORDIC chain.
	logic v_q;
	logic rdy_q;
	cd_t  quad_q;
	cd_t  quad_nxt;

	cd_t  cd_d [0:NSTG];
	logic cd_v [0:NSTG];
	logic cd_r [0:NSTG];

	logic                      out_v_q;
	logic                      rdy_out;
	logic signed [PITCH_W-1:0] pitch_q;
	logic signed [ROLL_W-1:0]  roll_q;
	logic signed [PITCH_W-1:0] pitch_nxt;
	logic signed [ROLL_W-1:0]  roll_nxt;

	function automatic lane_t quadrant(input logic signed [VEC_W-1:0] a,
			input logic signed [VEC_W-1:0] b);
		lane_t r;
		r.zero = (a == '0) && (b == '0);
		r.a    = a;
		r.b    = b;
		r.ang  = '0;
		if (b[VEC_W-1]) begin
			r.a   = -a;
			r.b   = -b;
			r.ang = a[VEC_W-1] ? -ANG_180 : ANG_180;
		end
		return r;
	endfunction

	function automatic logic signed [ANG_W-1:0] finish(input lane_t l,
			input logic signed [ANG_W-1:0] lim);
		logic signed [ANG_W-1:0] r;
		r = (l.ang + ROUND_BIAS) >>> ROUND_SH;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		if (l.zero) begin
			r = '0;
		end
		return r;
	endfunction

	// ---------------- squares ----------------
	always_comb begin
		yprod = sample.accel_y_raw * sample.accel_y_raw;
		zprod = sample.accel_z_raw * sample.accel_z_raw;
	end

	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			nx_s1  <= -{sample.accel_x_raw[AXIS_W-1], sample.accel_x_raw};
			y_s1   <= sample.accel_y_raw;
			z_s1   <= sample.accel_z_raw;
			ysq_s1 <= yprod[2*AXIS_W-2:0];
			zsq_s1 <= zprod[2*AXIS_W-2:0];
		end
	end

	// ---------------- sum of squares ----------------
	assign rdy_s2 = !v_s2 || sq_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			d_s2.sumsq <= {1'b0, ysq_s1} + {1'b0, zsq_s1};
			d_s2.rem   <= '0;
			d_s2.root  <= '0;
			d_s2.nx    <= nx_s1;
			d_s2.y     <= y_s1;
			d_s2.z     <= z_s1;
		end
	end

	assign sq_d[0] = d_s2;
	assign sq_v[0] = v_s2;

	// ---------------- square root chain ----------------
	for (genvar k = 0; k < SQ_DIGITS; k++) begin : g_sqrt
		atpr_sqrt_cell #(
			.DIGIT(SQ_DIGITS - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (sq_v[k]),
			.up_ready (sq_r[k]),
			.up_data  (sq_d[k]),
			.dn_valid (sq_v[k+1]),
			.dn_ready (sq_r[k+1]),
			.dn_data  (sq_d[k+1])
		);
	end

	// ---------------- quadrant ----------------
	always_comb begin
		quad_nxt.pitch = quadrant(
			VEC_W'(sq_d[SQ_DIGITS].nx) <<< VEC_SH,
			$signed(VEC_W'(sq_d[SQ_DIGITS].root)) <<< VEC_SH - VEC_SH);
		quad_nxt.roll = quadrant(
			VEC_W'(sq_d[SQ_DIGITS].y) <<< VEC_SH,
			VEC_W'(sq_d[SQ_DIGITS].z) <<< VEC_SH);
	end

	assign rdy_q             = !v_q || cd_r[0];
	assign sq_r[SQ_DIGITS]   = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy_q) begin
			v_q <= sq_v[SQ_DIGITS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_q && sq_v[SQ_DIGITS]) begin
			quad_q <= quad_nxt;
		end
	end

	assign cd_d[0] = quad_q;
	assign cd_v[0] = v_q;

	// ---------------- CORDIC chain ----------------
	for (genvar i = 0; i < NSTG; i++) begin : g_cordic
		atpr_cordic_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cd_v[i]),
			.up_ready (cd_r[i]),
			.up_data  (cd_d[i]),
			.dn_valid (cd_v[i+1]),
			.dn_ready (cd_r[i+1]),
			.dn_data  (cd_d[i+1])
		);
	end

	// ---------------- rounding and output register ----------------
	always_comb begin
		pitch_nxt = PITCH_W'(finish(cd_d[NSTG].pitch, PITCH_LIM));
		roll_nxt  = ROLL_W'(finish(cd_d[NSTG].roll, ROLL_LIM));
	end

	assign rdy_out    = !out_v_q || tilt.ready;
	assign cd_r[NSTG] = rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= cd_v[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && cd_v[NSTG]) begin
			pitch_q <= pitch_nxt;
			roll_q  <= roll_nxt;
		end
	end

	assign tilt.valid     = out_v_q;
	assign tilt.pitch_deg = pitch_q;
	assign tilt.roll_deg  = roll_q;

endmodule

[hw/rtl/atpr_check.sv]
`timescale 1ns / 1ps

module atpr_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [atpr_pkg::PITCH_W-1:0] pitch_deg,
	input logic signed [atpr_pkg::ROLL_W-1:0]  roll_deg
);
	import atpr_pkg::*;

	// A result word that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("tilt word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pitch_deg) && $stable(roll_deg))
		else $error("tilt word changed while stalled");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_deg >= -PITCH_W'(11520)) && (pitch_deg <= PITCH_W'(11520)))
		else $error("pitch out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_deg >= -ROLL_W'(23040)) && (roll_deg <= ROLL_W'(23040)))
		else $error("roll out of range");

	// With no word waiting at the output the pipeline can always take a sample.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output empty");

endmodule

bind accel_tilt_pitch_roll atpr_check u_atpr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (tilt.valid),
	.out_ready (tilt.ready),
	.pitch_deg (tilt.pitch_deg),
	.roll_deg  (tilt.roll_deg)
);
